@@ sv/assert_macros.svh @@
// Assertion macros included by cht_datapath.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Concurrent check, masked while reset is held.
`define CHT_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("hash table assertion failed");
// Concurrent check, live through reset.
`define CHT_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("hash table assertion failed");
`else
`define CHT_ASSERT(lbl, clk, rstn, prop)
`define CHT_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

@@ sv/cht_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package cht_pkg;

    localparam int MAX_BUCKETS_DEF   = 128;
    localparam int NODE_CAPACITY_DEF = 256;
    localparam int KEY_BYTES_DEF     = 8;

    localparam logic [7:0] RESET_BUCKET_COUNT = 8'd100;

    // key words are summed before the modulo: 33-bit sum, 4 dividend bits a step
    localparam int SUM_W      = 33;
    localparam int DIGIT_BITS = 4;
    localparam int HASH_STEPS = (SUM_W + DIGIT_BITS - 1) / DIGIT_BITS;
    localparam int PAD_W      = HASH_STEPS * DIGIT_BITS;

    localparam logic [2:0] STATUS_INSERTED  = 3'd0;
    localparam logic [2:0] STATUS_DUPLICATE = 3'd1;
    localparam logic [2:0] STATUS_FOUND     = 3'd2;
    localparam logic [2:0] STATUS_NOT_FOUND = 3'd3;
    localparam logic [2:0] STATUS_FULL      = 3'd4;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_SEARCH = 1'b1;

    typedef struct packed {
        logic               func;
        logic [63:0]        key;
        logic signed [31:0] value;
    } req_t;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] found_value;
        logic [6:0]         bucket;
        logic [8:0]         element_total;
        logic [8:0]         collision_total;
    } rsp_t;

    typedef struct packed {
        logic       load;
        logic       hash_step;
        logic       head_rd;
        logic       first_rd;
        logic       node_rd;
        logic       walk_adv;
        logic       set_status;
        logic [2:0] status;
        logic       insert;
        logic       rsp_load;
    } cmd_t;

    typedef struct packed {
        logic hash_done;
        logic used;
        logic key_match;
        logic at_tail;
        logic full;
        logic out_free;
        logic is_search;
    } sts_t;

endpackage
`default_nettype wire

@@ sv/cht_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
module cht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic                                   aclk,
    input  wire logic                                   we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic                                   re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule
`default_nettype wire

@@ sv/cht_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module cht_datapath #(
    parameter int MAX_BUCKETS   = cht_pkg::MAX_BUCKETS_DEF,
    parameter int NODE_CAPACITY = cht_pkg::NODE_CAPACITY_DEF,
    parameter int KEY_BYTES     = cht_pkg::KEY_BYTES_DEF
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          cfg_valid,
    input  wire logic [7:0]    cfg_data,
    input  wire cht_pkg::req_t s_req,
    output cht_pkg::rsp_t      m_rsp,
    output logic               m_valid,
    input  wire logic          m_ready,
    input  wire cht_pkg::cmd_t cmd,
    output cht_pkg::sts_t      sts
);
    localparam int KEY_W  = KEY_BYTES * 8;
    localparam int BW     = MAX_BUCKETS > 1 ? $clog2(MAX_BUCKETS) : 1;
    localparam int RW     = BW + 1;
    localparam int NODE_W = NODE_CAPACITY > 1 ? $clog2(NODE_CAPACITY) : 1;
    localparam int CNT_W  = $clog2(NODE_CAPACITY + 1);
    localparam int SC_W   = $clog2(cht_pkg::HASH_STEPS + 1);

    logic [7:0]             bcount_reg;
    logic                   func_reg;
    logic [KEY_W-1:0]       key_reg;
    logic [31:0]            value_reg;
    logic [RW-1:0]          n_reg;
    logic [RW-1:0]          rem_reg, rem_next;
    logic [cht_pkg::PAD_W-1:0] div_reg;
    logic [SC_W-1:0]        step_reg;
    logic [NODE_W-1:0]      cur_reg;
    logic [CNT_W-1:0]       elem_cnt_reg;
    logic [CNT_W-1:0]       coll_cnt_reg;
    logic [MAX_BUCKETS-1:0] used_reg;
    logic [2:0]             status_reg;
    logic [31:0]            found_reg;
    cht_pkg::rsp_t          rsp_reg;
    logic                   rsp_valid_reg;

    logic [BW-1:0]          bucket;
    logic [NODE_W-1:0]      head_rdata, tail_rdata, next_rdata, node_addr, slot;
    logic [KEY_W-1:0]       key_rdata;
    logic [31:0]            value_rdata;
    logic [RW-1:0]          n_load;
    logic [cht_pkg::SUM_W-1:0] sum;

    assign bucket = rem_reg[BW-1:0];
    assign slot   = elem_cnt_reg[NODE_W-1:0];

    // clamp the bucket count into 1..MAX_BUCKETS
    always_comb begin
        priority if (bcount_reg == 8'd0) begin
            n_load = RW'(1);
        end else if (32'(bcount_reg) > MAX_BUCKETS) begin
            n_load = RW'(MAX_BUCKETS);
        end else begin
            n_load = RW'(bcount_reg);
        end
    end

    always_comb begin
        if (KEY_BYTES >= 8) begin
            sum = {1'b0, s_req.key[31:0]} + {1'b0, s_req.key[63:32]};
        end else begin
            sum = {1'b0, s_req.key[31:0]};
        end
    end

    // restoring remainder, four dividend bits per cycle
    always_comb begin
        logic [RW:0] t;
        rem_next = rem_reg;
        for (int i = 0; i < cht_pkg::DIGIT_BITS; i++) begin
            t = {rem_next, div_reg[cht_pkg::PAD_W-1-i]};
            if (t >= {1'b0, n_reg}) begin
                t = t - {1'b0, n_reg};
            end
            rem_next = t[RW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bcount_reg <= cht_pkg::RESET_BUCKET_COUNT;
        end else if (cfg_valid) begin
            bcount_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg  <= s_req.func;
            key_reg   <= s_req.key[KEY_W-1:0];
            value_reg <= s_req.value;
            n_reg     <= n_load;
            rem_reg   <= '0;
            div_reg   <= cht_pkg::PAD_W'(sum);
            step_reg  <= '0;
        end else if (cmd.hash_step) begin
            rem_reg  <= rem_next;
            div_reg  <= div_reg << cht_pkg::DIGIT_BITS;
            step_reg <= step_reg + 1'b1;
        end
        if (cmd.first_rd) begin
            cur_reg <= head_rdata;
        end else if (cmd.walk_adv) begin
            cur_reg <= next_rdata;
        end
        if (cmd.set_status) begin
            status_reg <= cmd.status;
            found_reg  <= (cmd.status == cht_pkg::STATUS_FOUND) ? value_rdata : 32'd0;
        end
        if (cmd.rsp_load) begin
            rsp_reg.status          <= status_reg;
            rsp_reg.found_value     <= found_reg;
            rsp_reg.bucket          <= 7'(bucket);
            rsp_reg.element_total   <= 9'(elem_cnt_reg);
            rsp_reg.collision_total <= 9'(coll_cnt_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            elem_cnt_reg  <= '0;
            coll_cnt_reg  <= '0;
            used_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end else begin
            if (cmd.insert) begin
                elem_cnt_reg     <= elem_cnt_reg + 1'b1;
                used_reg[bucket] <= 1'b1;
                if (used_reg[bucket]) begin
                    coll_cnt_reg <= coll_cnt_reg + 1'b1;
                end
            end
            if (cmd.rsp_load) begin
                rsp_valid_reg <= 1'b1;
            end else if (m_ready) begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    assign node_addr = cmd.first_rd ? head_rdata : cur_reg;

    cht_ram #(.WIDTH(NODE_W), .DEPTH(MAX_BUCKETS)) u_head (
        .aclk(aclk), .we(cmd.insert && !used_reg[bucket]), .waddr(bucket), .wdata(slot),
        .re(cmd.head_rd), .raddr(bucket), .rdata(head_rdata)
    );
    cht_ram #(.WIDTH(NODE_W), .DEPTH(MAX_BUCKETS)) u_tail (
        .aclk(aclk), .we(cmd.insert), .waddr(bucket), .wdata(slot),
        .re(cmd.head_rd), .raddr(bucket), .rdata(tail_rdata)
    );
    cht_ram #(.WIDTH(KEY_W), .DEPTH(NODE_CAPACITY)) u_key (
        .aclk(aclk), .we(cmd.insert), .waddr(slot), .wdata(key_reg),
        .re(cmd.first_rd || cmd.node_rd), .raddr(node_addr), .rdata(key_rdata)
    );
    cht_ram #(.WIDTH(32), .DEPTH(NODE_CAPACITY)) u_value (
        .aclk(aclk), .we(cmd.insert), .waddr(slot), .wdata(value_reg),
        .re(cmd.first_rd || cmd.node_rd), .raddr(node_addr), .rdata(value_rdata)
    );
    // link the old tail to the new node
    cht_ram #(.WIDTH(NODE_W), .DEPTH(NODE_CAPACITY)) u_next (
        .aclk(aclk), .we(cmd.insert && used_reg[bucket]), .waddr(tail_rdata), .wdata(slot),
        .re(cmd.first_rd || cmd.node_rd), .raddr(node_addr), .rdata(next_rdata)
    );

    assign sts.hash_done = (step_reg == SC_W'(cht_pkg::HASH_STEPS - 1));
    assign sts.used      = used_reg[bucket];
    assign sts.key_match = (key_rdata == key_reg);
    assign sts.at_tail   = (cur_reg == tail_rdata);
    assign sts.full      = (32'(elem_cnt_reg) >= NODE_CAPACITY);
    assign sts.out_free  = !rsp_valid_reg || m_ready;
    assign sts.is_search = (func_reg == cht_pkg::FUNC_SEARCH);

    assign m_rsp   = rsp_reg;
    assign m_valid = rsp_valid_reg;

    `CHT_ASSERT(a_cnt_cap, aclk, aresetn, 32'(elem_cnt_reg) <= NODE_CAPACITY)
    `CHT_ASSERT(a_coll_le_elem, aclk, aresetn, coll_cnt_reg <= elem_cnt_reg)
    `CHT_ASSERT(a_insert_count, aclk, aresetn, cmd.insert |=> elem_cnt_reg == $past(elem_cnt_reg) + 1'b1)
    `CHT_ASSERT(a_rem_range, aclk, aresetn, cmd.hash_step |=> rem_reg < n_reg)
endmodule
`default_nettype wire

@@ sv/cht_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
module cht_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire cht_pkg::sts_t sts,
    output cht_pkg::cmd_t      cmd
);
    typedef enum logic [8:0] {
        IDLE   = 9'b000000001,
        HASH   = 9'b000000010,
        LOOKUP = 9'b000000100,
        FIRST  = 9'b000001000,
        FETCH  = 9'b000010000,
        CHECK  = 9'b000100000,
        HIT    = 9'b001000000,
        MISS   = 9'b010000000,
        RESP   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = HASH;
                end
            end
            HASH: begin
                cmd.hash_step = 1'b1;
                if (sts.hash_done) begin
                    state_next = LOOKUP;
                end
            end
            LOOKUP: begin
                cmd.head_rd = 1'b1;
                state_next  = sts.used ? FIRST : MISS;
            end
            FIRST: begin
                cmd.first_rd = 1'b1;
                state_next   = CHECK;
            end
            FETCH: begin
                cmd.node_rd = 1'b1;
                state_next  = CHECK;
            end
            CHECK: begin
                priority if (sts.key_match) begin
                    state_next = HIT;
                end else if (sts.at_tail) begin
                    state_next = MISS;
                end else begin
                    cmd.walk_adv = 1'b1;
                    state_next   = FETCH;
                end
            end
            HIT: begin
                cmd.set_status = 1'b1;
                cmd.status     = sts.is_search ? cht_pkg::STATUS_FOUND
                                               : cht_pkg::STATUS_DUPLICATE;
                state_next     = RESP;
            end
            MISS: begin
                cmd.set_status = 1'b1;
                priority if (sts.is_search) begin
                    cmd.status = cht_pkg::STATUS_NOT_FOUND;
                end else if (sts.full) begin
                    cmd.status = cht_pkg::STATUS_FULL;
                end else begin
                    cmd.status = cht_pkg::STATUS_INSERTED;
                    cmd.insert = 1'b1;
                end
                state_next = RESP;
            end
            RESP: begin
                // hold until the output register is free
                if (sts.out_free) begin
                    cmd.rsp_load = 1'b1;
                    state_next   = IDLE;
                end
            end
            default: begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == IDLE);
endmodule
`default_nettype wire

@@ sv/chained_hash_table_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// channel   direction  handshake            payload
// s_        in         s_valid / s_ready    s_req  (func, key, value)
// m_        out        m_valid / m_ready    m_rsp  (status, found_value, bucket, totals)
// cfg_      in         cfg_valid/cfg_ready  cfg_data (bucket count)
//
// An item goes from acceptance through the remainder unit (four bits a cycle), the head
// memory lookup and a walk of the chain nodes, then into the result register.
// Each chain node costs one registered node memory read and one compare.
// Synchronous active-low reset clears the bucket-used flags and counters; no clearing pass.
// A stalled result sits in the output register while the next request is taken.
module chained_hash_table_unit #(
    parameter int MAX_BUCKETS   = cht_pkg::MAX_BUCKETS_DEF,
    parameter int NODE_CAPACITY = cht_pkg::NODE_CAPACITY_DEF,
    parameter int KEY_BYTES     = cht_pkg::KEY_BYTES_DEF
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire cht_pkg::req_t s_req,
    output logic               m_valid,
    input  wire logic          m_ready,
    output cht_pkg::rsp_t      m_rsp,
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [7:0]    cfg_data
);
    cht_pkg::cmd_t cmd;
    cht_pkg::sts_t sts;

    assign cfg_ready = 1'b1;

    cht_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .sts(sts), .cmd(cmd)
    );

    cht_datapath #(
        .MAX_BUCKETS(MAX_BUCKETS), .NODE_CAPACITY(NODE_CAPACITY), .KEY_BYTES(KEY_BYTES)
    ) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cfg_valid(cfg_valid), .cfg_data(cfg_data),
        .s_req(s_req), .m_rsp(m_rsp), .m_valid(m_valid), .m_ready(m_ready),
        .cmd(cmd), .sts(sts)
    );
endmodule
`default_nettype wire

@@ dv/tb.sv @@
`timescale 1ns / 1ps
module tb;
    import cht_pkg::*;

    localparam int NODES = 256;
    localparam int HEADS = 128;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    req_t       s_req;
    logic       m_valid;
    logic       m_ready;
    rsp_t       m_rsp;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [7:0] cfg_data;

    chained_hash_table_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_req     (s_req),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_rsp     (m_rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        aclk = 1'b1;
        #2;
        aclk = 1'b0;
        #2;
    end

    // shadow copy of the table
    logic [63:0] shadow_key  [NODES];
    logic [31:0] shadow_val  [NODES];
    int unsigned shadow_link [NODES];
    int unsigned shadow_head [HEADS];
    int unsigned shadow_tail [HEADS];
    bit          shadow_used [HEADS];
    int unsigned shadow_elems;
    int unsigned shadow_colls;
    logic [7:0]  shadow_bcount;

    req_t        pending_reqs [$];
    rsp_t        expected_rsps [$];
    logic [63:0] issued_keys [$];
    bit          quiet;
    int          mismatches;
    int          src_gap;
    int          sink_gap;

    function automatic int unsigned hash_bucket(logic [63:0] k);
        int unsigned n;
        int unsigned acc;
        n = (shadow_bcount == 0) ? 1 : (shadow_bcount > HEADS) ? HEADS : shadow_bcount;
        acc = k[31:0] % n;
        acc = (acc + k[63:32] % n) % n;
        return acc;
    endfunction

    function automatic bit chain_lookup(int unsigned b, logic [63:0] k,
                                        output int unsigned where);
        int unsigned node;
        where = 0;
        if (!shadow_used[b])
            return 0;
        node = shadow_head[b];
        for (int unsigned i = 0; i < shadow_elems; i++) begin
            if (node >= NODES)
                break;
            if (shadow_key[node] == k) begin
                where = node;
                return 1;
            end
            if (node == shadow_tail[b])
                break;
            node = shadow_link[node];
        end
        return 0;
    endfunction

    function automatic rsp_t table_update(req_t r);
        rsp_t        o;
        int unsigned b;
        int unsigned where;
        int unsigned slot;
        b = hash_bucket(r.key);
        o.found_value = '0;
        if (r.func == FUNC_SEARCH) begin
            if (chain_lookup(b, r.key, where)) begin
                o.status = STATUS_FOUND;
                o.found_value = shadow_val[where];
            end else begin
                o.status = STATUS_NOT_FOUND;
            end
        end else if (chain_lookup(b, r.key, where)) begin
            o.status = STATUS_DUPLICATE;
        end else if (shadow_elems >= NODES) begin
            o.status = STATUS_FULL;
        end else begin
            slot = shadow_elems;
            shadow_key[slot] = r.key;
            shadow_val[slot] = r.value;
            shadow_link[slot] = 0;
            if (shadow_used[b]) begin
                shadow_link[shadow_tail[b]] = slot;
                shadow_colls++;
            end else begin
                shadow_head[b] = slot;
                shadow_used[b] = 1;
            end
            shadow_tail[b] = slot;
            shadow_elems++;
            o.status = STATUS_INSERTED;
        end
        o.bucket = b[6:0];
        o.element_total = shadow_elems[8:0];
        o.collision_total = shadow_colls[8:0];
        return o;
    endfunction

    function automatic logic [63:0] fresh_key();
        case ($urandom_range(0, 3))
            0: return {32'h0, $urandom()};
            1: return {$urandom(), 32'h0};
            2: return {32'($urandom_range(0, 300)), 32'($urandom_range(0, 300))};
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    task automatic queue_req(logic f, logic [63:0] k, logic [31:0] v);
        req_t r;
        r.func = f;
        r.key = k;
        r.value = v;
        pending_reqs.push_back(r);
        if (f == FUNC_INSERT)
            issued_keys.push_back(k);
    endtask

    task automatic queue_random(int count);
        int          pick;
        logic [63:0] k;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 99);
            k = (pick < 18 || pick >= 85) ? fresh_key()
                : issued_keys[$urandom_range(0, issued_keys.size() - 1)];
            queue_req((pick < 35) ? FUNC_INSERT : FUNC_SEARCH, k, $urandom());
        end
    endtask

    task automatic wait_drained();
        do @(negedge aclk);
        while (pending_reqs.size() != 0 || s_valid || expected_rsps.size() != 0);
    endtask

    task automatic write_bcount(logic [7:0] v);
        @(posedge aclk);
        cfg_data <= v;
        cfg_valid <= 1'b1;
        do @(posedge aclk);
        while (!cfg_ready);
        shadow_bcount = v;
        cfg_valid <= 1'b0;
    endtask

    // request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            src_gap = 0;
        end else begin
            if (s_valid && s_ready)
                expected_rsps.push_back(table_update(s_req));
            if (!(s_valid && !s_ready)) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_valid <= 1'b0;
                end else if (pending_reqs.size() != 0) begin
                    s_req <= pending_reqs.pop_front();
                    s_valid <= 1'b1;
                    if (!quiet && $urandom_range(0, 7) == 0)
                        src_gap = $urandom_range(1, 16);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // response monitor
    always @(posedge aclk) begin
        rsp_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
            sink_gap = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_rsps.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected response %p", m_rsp);
                end else begin
                    want = expected_rsps.pop_front();
                    if (m_rsp !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %p got %p", want, m_rsp);
                    end
                end
            end
            if (sink_gap > 0) begin
                sink_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (!quiet && $urandom_range(0, 7) == 0)
                    sink_gap = $urandom_range(1, 16);
            end
        end
    end

    initial begin
        #20_000_000;
        $display("tb: FAIL");
        $finish;
    end

    initial begin
        logic [7:0] phase_bcount [10];
        phase_bcount = '{8'd0, 8'd255, 8'd128, 8'd1, RESET_BUCKET_COUNT, 8'd2, 8'd127,
                         8'($urandom_range(1, 128)), 8'($urandom_range(0, 255)),
                         8'($urandom_range(1, 128))};
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_req = '0;
        m_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        quiet = 0;
        mismatches = 0;
        shadow_elems = 0;
        shadow_colls = 0;
        shadow_bcount = RESET_BUCKET_COUNT;
        foreach (shadow_used[i])
            shadow_used[i] = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // reset bucket count first, then the extremes
        queue_req(FUNC_INSERT, 64'h0123_4567_89ab_cdef, 32'h1);
        queue_req(FUNC_SEARCH, 64'h0123_4567_89ab_cdef, 32'h0);
        wait_drained();
        for (int p = 0; p < 10; p++) begin
            write_bcount(phase_bcount[p]);
            if (p == 0) begin
                queue_req(FUNC_INSERT, 64'h0, 32'h8000_0000);
                queue_req(FUNC_INSERT, 64'hffff_ffff_ffff_ffff, 32'h7fff_ffff);
                queue_req(FUNC_INSERT, 64'h0, 32'h5);
                queue_req(FUNC_SEARCH, 64'h0, 32'hffff_ffff);
                queue_req(FUNC_SEARCH, 64'hffff_ffff_ffff_ffff, 32'h0);
                queue_req(FUNC_SEARCH, 64'h5, 32'h0);
                queue_req(FUNC_INSERT, 64'h0000_0001_0000_0000, 32'h0);
                queue_req(FUNC_SEARCH, 64'h0000_0001_0000_0000, 32'h0);
            end
            if (p == 9)
                quiet = 1;
            queue_random(p == 0 ? 170 : 190);
            wait_drained();
        end
        repeat (600) @(posedge aclk);
        if (mismatches == 0 && expected_rsps.size() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end
endmodule

@@ filelist.f @@
+incdir+sv
sv/cht_pkg.sv
sv/cht_ram.sv
sv/cht_datapath.sv
sv/cht_ctrl.sv
sv/chained_hash_table_unit.sv
dv/tb.sv
